// ===== rtl/core/prs_pkg.sv =====
// Package for the periodic refresh scheduler: event codes, item, result and
// configuration types, and fixed constants. No dependencies.
`default_nettype none

package prs_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned MIN_W  = 12;
  localparam int unsigned CNT_W  = 8;
  // 4095 minutes of 60000 ticks still fits in 28 bits
  localparam int unsigned IVL_W  = 28;

  localparam logic [15:0] TICKS_PER_MINUTE = 16'd60000;
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ACT_POLL    = 3'd0,
    ACT_BEGIN   = 3'd1,
    ACT_SUCCESS = 3'd2,
    ACT_DEFER   = 3'd3,
    ACT_CANCEL  = 3'd4,
    ACT_INIT    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    FST_NONE      = 2'd0,
    FST_DEFERRED  = 2'd1,
    FST_EXHAUSTED = 2'd2
  } fail_status_e;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_INTERVAL  = 2'd1,
    REG_RETRY     = 2'd2,
    REG_MAX_FAIL  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [TICK_W-1:0] now;
    logic              window_ready;
  } item_t;

  typedef struct packed {
    logic              enable;
    logic [MIN_W-1:0]  interval_minutes;
    logic [TICK_W-1:0] retry_delay_ticks;
    logic [CNT_W-1:0]  max_failed_rounds;
  } cfg_t;

  typedef struct packed {
    logic             ready_res;
    fail_status_e     failure_status;
    logic             is_armed;
    logic             is_pending;
    logic             is_active;
    logic             is_exhausted;
    logic [CNT_W-1:0] failed_count;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/prs_core.sv =====
// Scheduler state and single-pass event logic: one item per fire, result
// returned combinationally. Depends on prs_pkg.
`default_nettype none

module prs_core #(
  parameter int unsigned MIN_INTERVAL_MINUTES = 1,
  parameter int unsigned MAX_INTERVAL_MINUTES = 1440
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire prs_pkg::item_t item_i,
  input  wire prs_pkg::cfg_t  cfg_i,
  output prs_pkg::result_t    res_o
);

  localparam logic [prs_pkg::MIN_W-1:0] MinIvl = prs_pkg::MIN_W'(MIN_INTERVAL_MINUTES);
  localparam logic [prs_pkg::MIN_W-1:0] MaxIvl = prs_pkg::MIN_W'(MAX_INTERVAL_MINUTES);

  logic                        enabled_q, enabled_d;
  logic [prs_pkg::IVL_W-1:0]   interval_q, interval_d;
  logic [prs_pkg::TICK_W-1:0]  anchor_q, anchor_d;
  logic [prs_pkg::TICK_W-1:0]  retry_q, retry_d;
  logic                        armed_q, armed_d;
  logic                        pending_q, pending_d;
  logic                        active_q, active_d;
  logic                        rwait_q, rwait_d;
  logic                        exh_q, exh_d;
  logic [prs_pkg::CNT_W-1:0]   rounds_q, rounds_d;

  logic [prs_pkg::TICK_W-1:0]  since_anchor, since_retry;
  logic [prs_pkg::CNT_W-1:0]   rounds_inc;
  logic [prs_pkg::IVL_W-1:0]   interval_calc;
  logic                        ivl_ok;
  logic                        poll_ok;
  logic                        ready;
  prs_pkg::fail_status_e       status;

  assign since_anchor  = item_i.now - anchor_q;
  assign since_retry   = item_i.now - retry_q;
  assign rounds_inc    = (rounds_q != prs_pkg::CNT_MAX) ? rounds_q + 1'b1 : rounds_q;
  assign interval_calc = prs_pkg::IVL_W'(cfg_i.interval_minutes) *
                         prs_pkg::IVL_W'(prs_pkg::TICKS_PER_MINUTE);
  assign ivl_ok        = (cfg_i.interval_minutes >= MinIvl) &&
                         (cfg_i.interval_minutes <= MaxIvl);

  always_comb begin
    enabled_d  = enabled_q;
    interval_d = interval_q;
    anchor_d   = anchor_q;
    retry_d    = retry_q;
    armed_d    = armed_q;
    pending_d  = pending_q;
    active_d   = active_q;
    rwait_d    = rwait_q;
    exh_d      = exh_q;
    rounds_d   = rounds_q;
    poll_ok    = 1'b0;
    ready      = 1'b0;
    status     = prs_pkg::FST_NONE;

    case (prs_pkg::action_e'(item_i.action))
      prs_pkg::ACT_POLL, prs_pkg::ACT_BEGIN: begin
        if (enabled_q && !exh_q) begin
          if (!armed_q) begin
            if (item_i.window_ready) begin
              anchor_d = item_i.now;
              armed_d  = 1'b1;
            end
          end else begin
            pending_d = pending_q ||
                        (since_anchor >= prs_pkg::TICK_W'(interval_q));
            if (rwait_q && (since_retry < cfg_i.retry_delay_ticks)) begin
              poll_ok = 1'b0;
            end else begin
              // retry wait is dropped even if the answer turns out not ready
              rwait_d = 1'b0;
              poll_ok = pending_d && !active_q && item_i.window_ready;
            end
          end
        end
        ready = poll_ok;
        if (poll_ok && (prs_pkg::action_e'(item_i.action) == prs_pkg::ACT_BEGIN)) begin
          active_d = 1'b1;
        end
      end
      prs_pkg::ACT_SUCCESS: begin
        if (active_q) begin
          anchor_d  = item_i.now;
          rounds_d  = '0;
          armed_d   = 1'b1;
          pending_d = 1'b0;
          active_d  = 1'b0;
          rwait_d   = 1'b0;
        end
      end
      prs_pkg::ACT_DEFER: begin
        if (active_q) begin
          active_d  = 1'b0;
          pending_d = 1'b1;
          rounds_d  = rounds_inc;
          if (rounds_inc >= cfg_i.max_failed_rounds) begin
            exh_d   = 1'b1;
            rwait_d = 1'b0;
            status  = prs_pkg::FST_EXHAUSTED;
          end else begin
            retry_d = item_i.now;
            rwait_d = 1'b1;
            status  = prs_pkg::FST_DEFERRED;
          end
        end
      end
      prs_pkg::ACT_CANCEL: begin
        active_d = 1'b0;
      end
      prs_pkg::ACT_INIT: begin
        enabled_d  = 1'b0;
        interval_d = '0;
        anchor_d   = '0;
        retry_d    = '0;
        armed_d    = 1'b0;
        pending_d  = 1'b0;
        active_d   = 1'b0;
        rwait_d    = 1'b0;
        exh_d      = 1'b0;
        rounds_d   = '0;
        if (ivl_ok) begin
          enabled_d  = cfg_i.enable;
          interval_d = interval_calc;
          ready      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      interval_q <= '0;
      anchor_q   <= '0;
      retry_q    <= '0;
      armed_q    <= 1'b0;
      pending_q  <= 1'b0;
      active_q   <= 1'b0;
      rwait_q    <= 1'b0;
      exh_q      <= 1'b0;
      rounds_q   <= '0;
    end else if (fire_i) begin
      enabled_q  <= enabled_d;
      interval_q <= interval_d;
      anchor_q   <= anchor_d;
      retry_q    <= retry_d;
      armed_q    <= armed_d;
      pending_q  <= pending_d;
      active_q   <= active_d;
      rwait_q    <= rwait_d;
      exh_q      <= exh_d;
      rounds_q   <= rounds_d;
    end
  end

  always_comb begin
    res_o.ready_res      = ready;
    res_o.failure_status = status;
    res_o.is_armed       = armed_d;
    res_o.is_pending     = pending_d;
    res_o.is_active      = active_d;
    res_o.is_exhausted   = exh_d;
    res_o.failed_count   = rounds_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/periodic_refresh_scheduler_top.sv =====
// Top level of the periodic refresh scheduler: stream ports, configuration
// registers, input and result registers around prs_core. Depends on prs_pkg.
// Flow: a taken item waits in the input register until the result register can take
//   its result, which is then offered; throughput 1 item per cycle unless the output stalls.
// The event logic is a single subtract/compare pass against the state registers.
// Reset (rst_ni low, asynchronous): stream registers empty, schedule state cleared,
//   configuration back to enable 0, 60 minutes, 60000 ticks, 3 rounds.
`default_nettype none

module periodic_refresh_scheduler_top #(
  parameter int unsigned MIN_INTERVAL_MINUTES = 1,
  parameter int unsigned MAX_INTERVAL_MINUTES = 1440
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output wire logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // now[31:0], window_ready[32], zero[39:33]
  input  wire logic [2:0]  s_axis_tuser,  // action[2:0]
  output wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output wire logic [15:0] m_axis_tdata,  // ready_res[0], failure_status[2:1],
                                          // is_armed[3], is_pending[4], is_active[5],
                                          // is_exhausted[6], failed_count[14:7], zero[15]
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  prs_pkg::cfg_t    cfg_q;
  logic             in_valid_q;
  prs_pkg::item_t   in_item_q;
  logic             out_valid_q;
  prs_pkg::result_t out_res_q;
  prs_pkg::result_t res;
  logic             fire;

  // process the held item once the result register can take its answer
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable            <= 1'b0;
      cfg_q.interval_minutes  <= 12'd60;
      cfg_q.retry_delay_ticks <= 32'd60000;
      cfg_q.max_failed_rounds <= 8'd3;
    end else if (cfg_we_i) begin
      case (prs_pkg::reg_idx_e'(cfg_idx_i))
        prs_pkg::REG_ENABLE:   cfg_q.enable            <= cfg_data_i[0];
        prs_pkg::REG_INTERVAL: cfg_q.interval_minutes  <= cfg_data_i[11:0];
        prs_pkg::REG_RETRY:    cfg_q.retry_delay_ticks <= cfg_data_i;
        prs_pkg::REG_MAX_FAIL: cfg_q.max_failed_rounds <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.action       <= s_axis_tuser;
      in_item_q.now          <= s_axis_tdata[31:0];
      in_item_q.window_ready <= s_axis_tdata[32];
    end
  end

  prs_core #(
    .MIN_INTERVAL_MINUTES(MIN_INTERVAL_MINUTES),
    .MAX_INTERVAL_MINUTES(MAX_INTERVAL_MINUTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.failed_count,
                          out_res_q.is_exhausted,
                          out_res_q.is_active,
                          out_res_q.is_pending,
                          out_res_q.is_armed,
                          out_res_q.failure_status,
                          out_res_q.ready_res};

  // a running refresh always has an anchor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[3])
    else $error("active refresh without anchor");

  // an exhausted schedule never has a refresh running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> !m_axis_tdata[5])
    else $error("active refresh on exhausted schedule");

  // poll/begin answer and defer status never both set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[2:1] == 2'd0))
    else $error("ready and failure status both set");

  // a held item that could not be processed stays held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_item_q))
    else $error("held item lost");

endmodule

`default_nettype wire

// ===== tb/tb_periodic_refresh_scheduler_top.sv =====
// Self-checking testbench for periodic_refresh_scheduler_top: drives scheduler events on the
// input stream and compares every status report against an in-bench schedule predictor.
// Depends on prs_pkg and the periodic_refresh_scheduler_top RTL.
module tb_periodic_refresh_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned IVL_MIN_OK   = 1;
  localparam int unsigned IVL_MAX_OK   = 1440;
  // codes past ACT_INIT carry no meaning; the block must ignore them
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  wire         s_axis_tready;
  logic [39:0] s_axis_tdata;   // now[31:0], window_ready[32], zero[39:33]
  logic [2:0]  s_axis_tuser;   // action[2:0]
  wire         m_axis_tvalid;
  logic        m_axis_tready;
  wire  [15:0] m_axis_tdata;   // ready_res[0], failure_status[2:1], is_armed[3], is_pending[4],
                               // is_active[5], is_exhausted[6], failed_count[14:7], zero[15]
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  periodic_refresh_scheduler_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // configuration mirror
  logic                      c_enable     = 1'b0;
  logic [prs_pkg::MIN_W-1:0] c_minutes    = 12'd60;
  logic [31:0]               c_retry      = 32'd60000;
  logic [prs_pkg::CNT_W-1:0] c_max_fail   = 8'd3;

  // schedule state mirror
  logic                      p_enabled    = 1'b0;
  logic [31:0]               p_ivl_ticks  = '0;
  logic [31:0]               p_anchor     = '0;
  logic [31:0]               p_retry_at   = '0;
  logic                      p_armed      = 1'b0;
  logic                      p_pending    = 1'b0;
  logic                      p_active     = 1'b0;
  logic                      p_retry_wait = 1'b0;
  logic                      p_exhausted  = 1'b0;
  logic [prs_pkg::CNT_W-1:0] p_fail_cnt   = '0;

  prs_pkg::result_t awaited_reports[$];
  prs_pkg::result_t next_report;
  prs_pkg::result_t got_report;
  logic [31:0] tick = '0;
  int unsigned events_sent    = 0;
  int unsigned events_taken   = 0;
  int unsigned reports_seen   = 0;
  int unsigned ready_answers  = 0;
  int unsigned exhaust_events = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_cycles    = 0;
  int unsigned burst_left     = 0;
  int unsigned rx_phase       = 0;
  logic        tx_bursty      = 1'b0;
  rx_mode_e    rx_mode        = RX_ALWAYS;

  function automatic void clear_schedule();
    p_enabled    = 1'b0;
    p_ivl_ticks  = '0;
    p_anchor     = '0;
    p_retry_at   = '0;
    p_armed      = 1'b0;
    p_pending    = 1'b0;
    p_active     = 1'b0;
    p_retry_wait = 1'b0;
    p_exhausted  = 1'b0;
    p_fail_cnt   = '0;
  endfunction

  // shared by poll and begin: may arm, mark due, and end the retry wait
  function automatic logic refresh_allowed(input logic [31:0] now, input logic win);
    logic [31:0] since_anchor;
    logic [31:0] since_retry;
    since_anchor = now - p_anchor;
    since_retry  = now - p_retry_at;
    if (!p_enabled || p_exhausted) return 1'b0;
    if (!p_armed) begin
      if (win) begin
        p_anchor = now;
        p_armed  = 1'b1;
      end
      return 1'b0;
    end
    if (since_anchor >= p_ivl_ticks) p_pending = 1'b1;
    if (p_retry_wait) begin
      if (since_retry < c_retry) return 1'b0;
      p_retry_wait = 1'b0;
    end
    return p_pending && !p_active && win;
  endfunction

  function automatic prs_pkg::result_t schedule_step(input logic [2:0] act,
                                                     input logic [31:0] now,
                                                     input logic win);
    prs_pkg::result_t r;
    r = '0;
    case (act)
      prs_pkg::ACT_POLL: r.ready_res = refresh_allowed(now, win);
      prs_pkg::ACT_BEGIN: begin
        if (refresh_allowed(now, win)) begin
          p_active    = 1'b1;
          r.ready_res = 1'b1;
        end
      end
      prs_pkg::ACT_SUCCESS: begin
        if (p_active) begin
          p_anchor     = now;
          p_fail_cnt   = '0;
          p_armed      = 1'b1;
          p_pending    = 1'b0;
          p_active     = 1'b0;
          p_retry_wait = 1'b0;
        end
      end
      prs_pkg::ACT_DEFER: begin
        if (p_active) begin
          p_active  = 1'b0;
          p_pending = 1'b1;
          if (p_fail_cnt != prs_pkg::CNT_MAX) p_fail_cnt = p_fail_cnt + 1'b1;
          if (p_fail_cnt >= c_max_fail) begin
            p_exhausted      = 1'b1;
            p_retry_wait     = 1'b0;
            r.failure_status = prs_pkg::FST_EXHAUSTED;
          end else begin
            p_retry_at       = now;
            p_retry_wait     = 1'b1;
            r.failure_status = prs_pkg::FST_DEFERRED;
          end
        end
      end
      prs_pkg::ACT_CANCEL: p_active = 1'b0;
      prs_pkg::ACT_INIT: begin
        clear_schedule();
        if (32'(c_minutes) >= IVL_MIN_OK && 32'(c_minutes) <= IVL_MAX_OK) begin
          p_enabled   = c_enable;
          p_ivl_ticks = 32'(c_minutes) * 32'(prs_pkg::TICKS_PER_MINUTE);
          r.ready_res = 1'b1;
        end
      end
      default: ;
    endcase
    r.is_armed     = p_armed;
    r.is_pending   = p_pending;
    r.is_active    = p_active;
    r.is_exhausted = p_exhausted;
    r.failed_count = p_fail_cnt;
    return r;
  endfunction

  // predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      next_report = schedule_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[32]);
      awaited_reports.push_back(next_report);
      events_taken++;
      if (next_report.ready_res) ready_answers++;
      if (next_report.failure_status == prs_pkg::FST_EXHAUSTED) exhaust_events++;
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on report %0d: %s expected %0d, got %0d", reports_seen, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reports_seen++;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report %0d: data 0x%04h", reports_seen, m_axis_tdata);
      end else begin
        got_report = awaited_reports.pop_front();
        check_field("ready_res", 32'(got_report.ready_res), 32'(m_axis_tdata[0]));
        check_field("failure_status", 32'(got_report.failure_status),
                    32'(m_axis_tdata[2:1]));
        check_field("is_armed", 32'(got_report.is_armed), 32'(m_axis_tdata[3]));
        check_field("is_pending", 32'(got_report.is_pending), 32'(m_axis_tdata[4]));
        check_field("is_active", 32'(got_report.is_active), 32'(m_axis_tdata[5]));
        check_field("is_exhausted", 32'(got_report.is_exhausted), 32'(m_axis_tdata[6]));
        check_field("failed_count", 32'(got_report.failed_count), 32'(m_axis_tdata[14:7]));
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    rx_phase = (rx_phase == 10) ? 0 : rx_phase + 1;
    if (hold_cycles != 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_LIGHT:   m_axis_tready <= ($urandom_range(0, 9) != 0);
        RX_HEAVY:   m_axis_tready <= ($urandom_range(0, 2) == 0);
        RX_PATTERN: m_axis_tready <= (rx_phase > 3);
        default:    m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               awaited_reports.size());
      $display("periodic_refresh_scheduler_top regression: fail");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] act, input logic [31:0] now, input logic win);
    int unsigned gap;
    if (tx_bursty && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'd0, win, now};
    do @(posedge clk_i); while (!s_axis_tready);
    events_sent++;
    if (burst_left != 0) burst_left--;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // idle-only write of all four registers
  task automatic program_cfg(input logic en, input logic [prs_pkg::MIN_W-1:0] minutes,
                             input logic [31:0] retry,
                             input logic [prs_pkg::CNT_W-1:0] max_fail);
    wait_drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= prs_pkg::REG_ENABLE;
    cfg_data_i <= {31'd0, en};
    @(posedge clk_i);
    cfg_idx_i  <= prs_pkg::REG_INTERVAL;
    cfg_data_i <= {20'd0, minutes};
    @(posedge clk_i);
    cfg_idx_i  <= prs_pkg::REG_RETRY;
    cfg_data_i <= retry;
    @(posedge clk_i);
    cfg_idx_i  <= prs_pkg::REG_MAX_FAIL;
    cfg_data_i <= {24'd0, max_fail};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    c_enable   = en;
    c_minutes  = minutes;
    c_retry    = retry;
    c_max_fail = max_fail;
  endtask

  // tick advance scaled to the programmed interval, with rare arbitrary jumps
  function automatic logic [31:0] tick_step();
    logic [31:0] span;
    int unsigned pick;
    span = 32'(c_minutes) * 32'(prs_pkg::TICKS_PER_MINUTE);
    if (span == 0) span = 32'd60000;
    pick = $urandom_range(0, 19);
    if (pick == 0) return $urandom;
    if (pick < 7) return $urandom_range(0, 2000);
    if (pick < 15) return $urandom_range(0, span / 2);
    return $urandom_range(span / 2, span + span / 4);
  endfunction

  task automatic refresh_round();
    prs_pkg::action_e outcome;
    int unsigned      pick;
    tick += tick_step();
    send_event(prs_pkg::ACT_POLL, tick, $urandom_range(0, 9) != 0);
    if ($urandom_range(0, 2) == 0) begin
      tick += tick_step();
      send_event(prs_pkg::ACT_POLL, tick, 1'($urandom_range(0, 1)));
    end
    tick += $urandom_range(0, 50);
    send_event(prs_pkg::ACT_BEGIN, tick, $urandom_range(0, 6) != 0);
    tick += $urandom_range(0, 5000);
    pick = $urandom_range(0, 19);
    if (pick < 9) outcome = prs_pkg::ACT_SUCCESS;
    else if (pick < 17) outcome = prs_pkg::ACT_DEFER;
    else outcome = prs_pkg::ACT_CANCEL;
    send_event(outcome, tick, 1'($urandom_range(0, 1)));
  endtask

  task automatic noise_event();
    logic [2:0] act;
    act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    tick += tick_step();
    send_event(act, tick, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_event_walk();
    logic [31:0] t;
    program_cfg(1'b1, 12'd1, 32'd1000, 8'd2);
    t = 32'h0000_0100;
    send_event(prs_pkg::ACT_INIT, t, 1'b0);
    send_event(prs_pkg::ACT_POLL, t + 10, 1'b0);          // closed window does not arm
    send_event(prs_pkg::ACT_POLL, t + 20, 1'b1);          // anchor at t+20
    send_event(prs_pkg::ACT_BEGIN, t + 30, 1'b1);         // not yet due
    t = t + 20 + 60000;
    send_event(prs_pkg::ACT_POLL, t, 1'b0);               // due, window closed
    send_event(prs_pkg::ACT_BEGIN, t, 1'b1);
    send_event(prs_pkg::ACT_BEGIN, t + 1, 1'b1);          // already running
    t = t + 10000;
    send_event(prs_pkg::ACT_SUCCESS, t, 1'b1);            // re-anchor
    t = t + 60000;
    send_event(prs_pkg::ACT_POLL, t, 1'b1);
    send_event(prs_pkg::ACT_BEGIN, t, 1'b1);
    t = t + 10;
    send_event(prs_pkg::ACT_DEFER, t, 1'b0);              // first failure, retry wait
    send_event(prs_pkg::ACT_BEGIN, t + 500, 1'b1);        // still waiting
    send_event(prs_pkg::ACT_POLL, t + 1000, 1'b0);        // wait ends though answer is no
    send_event(prs_pkg::ACT_BEGIN, t + 1001, 1'b1);
    send_event(prs_pkg::ACT_CANCEL, t + 1002, 1'b1);
    send_event(prs_pkg::ACT_BEGIN, t + 1003, 1'b1);
    send_event(prs_pkg::ACT_DEFER, t + 1004, 1'b1);       // second failure exhausts
    send_event(prs_pkg::ACT_POLL, t + 1005, 1'b1);
    send_event(prs_pkg::ACT_DEFER, t + 1006, 1'b1);       // not running: no effect
    send_event(prs_pkg::ACT_SUCCESS, t + 1007, 1'b1);
    send_event(prs_pkg::ACT_CANCEL, t + 1008, 1'b0);
    send_event(ACT_SPARE_6, 32'hFFFF_FFFF, 1'b1);
    send_event(ACT_SPARE_7, 32'h0000_0000, 1'b0);
    // anchor just below the wrap point, due after the tick counter wraps
    send_event(prs_pkg::ACT_INIT, 32'hFFFF_FF00, 1'b1);
    send_event(prs_pkg::ACT_POLL, 32'hFFFF_FF00, 1'b1);
    send_event(prs_pkg::ACT_BEGIN, 32'hFFFF_FF00 + 32'd60000, 1'b1);
    tick = 32'hFFFF_FF00 + 32'd60100;
  endtask

  task automatic test_config_limits();
    program_cfg(1'b1, 12'd0, 32'd0, 8'd0);
    send_event(prs_pkg::ACT_INIT, tick, 1'b1);            // zero interval rejected
    send_event(prs_pkg::ACT_POLL, tick + 1, 1'b1);
    program_cfg(1'b1, 12'd1441, 32'd0, 8'd1);
    send_event(prs_pkg::ACT_INIT, tick + 2, 1'b1);
    program_cfg(1'b1, 12'd4095, 32'hFFFF_FFFF, 8'd255);
    send_event(prs_pkg::ACT_INIT, tick + 3, 1'b1);
    program_cfg(1'b0, 12'd1440, 32'hFFFF_FFFF, 8'd255);
    send_event(prs_pkg::ACT_INIT, tick + 4, 1'b1);        // accepted but disabled
    send_event(prs_pkg::ACT_POLL, tick + 5, 1'b1);
    // limit of zero: first failure exhausts
    program_cfg(1'b1, 12'd1, 32'd0, 8'd0);
    send_event(prs_pkg::ACT_INIT, tick, 1'b1);
    send_event(prs_pkg::ACT_POLL, tick, 1'b1);
    send_event(prs_pkg::ACT_BEGIN, tick + 60000, 1'b1);
    send_event(prs_pkg::ACT_DEFER, tick + 60001, 1'b1);
    // longest interval and retry delay
    program_cfg(1'b1, 12'd1440, 32'hFFFF_FFFF, 8'd255);
    send_event(prs_pkg::ACT_INIT, tick, 1'b1);
    send_event(prs_pkg::ACT_POLL, tick, 1'b1);
    tick += 32'd86_400_000;
    send_event(prs_pkg::ACT_BEGIN, tick, 1'b1);
    send_event(prs_pkg::ACT_DEFER, tick + 1, 1'b1);
    send_event(prs_pkg::ACT_BEGIN, tick + 32'h8000_0000, 1'b1);
    tick += 32'h8000_0001;
  endtask

  task automatic test_backpressure();
    program_cfg(1'b1, 12'd1, 32'd5000, 8'd4);
    rx_mode   = RX_ALWAYS;
    tx_bursty = 1'b0;
    send_event(prs_pkg::ACT_INIT, tick, 1'b1);
    hold_cycles = 300;
    repeat (15) refresh_round();
    wait_drain();                                // sender waits for every report
    repeat (5) refresh_round();
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned pick;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          program_cfg(1'b1, 12'd1, 32'd20000, 8'd3);
          rx_mode = RX_LIGHT;
          tx_bursty = 1'b1;
        end
        1: begin
          program_cfg(1'b1, 12'd2, 32'd0, 8'd1);
          rx_mode = RX_ALWAYS;
          tx_bursty = 1'b0;
        end
        2: begin
          program_cfg(1'b1, 12'd1440, 32'hFFFF_FFFF, 8'd255);
          rx_mode = RX_HEAVY;
          tx_bursty = 1'b1;
        end
        3: begin
          program_cfg($urandom_range(0, 3) != 0, 12'($urandom_range(1, 4)),
                      $urandom_range(0, 150000), 8'($urandom_range(1, 6)));
          rx_mode = RX_PATTERN;
          tx_bursty = 1'b1;
        end
        4: begin
          program_cfg(1'b1, 12'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 4095)
                                                            : $urandom_range(1, 3)),
                      $urandom, 8'($urandom_range(1, 255)));
          rx_mode = RX_LIGHT;
          tx_bursty = 1'b0;
        end
        default: begin
          program_cfg(1'b1, 12'd1, $urandom_range(0, 90000), 8'($urandom_range(2, 8)));
          rx_mode = RX_HEAVY;
          tx_bursty = 1'b0;
        end
      endcase
      stop_at = events_sent + ((ph == 4) ? 100 : 340);
      send_event(prs_pkg::ACT_INIT, tick, 1'b1);
      while (events_sent < stop_at) begin
        pick = $urandom_range(0, 39);
        if (pick < 8) noise_event();
        else if (pick == 8) send_event(prs_pkg::ACT_INIT, tick, 1'($urandom_range(0, 1)));
        else refresh_round();
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= prs_pkg::ACT_POLL;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= prs_pkg::REG_ENABLE;
    cfg_data_i    <= '0;
    clear_schedule();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_event_walk();
    test_config_limits();
    test_backpressure();
    test_random_traffic();
    wait_drain();

    $display("covered %0d events and %0d reports: %0d ready answers, %0d exhaustions,",
             events_taken, reports_seen, ready_answers, exhaust_events);
    $display("interval and limit extremes, tick wrap, output hold-off and input gaps");
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("periodic_refresh_scheduler_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d reports missing", mismatches, awaited_reports.size());
      $display("periodic_refresh_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
